FILE: rtl/multicore_job_scheduler_macros.svh
// Assertion helpers used by the checker file of the scheduler.
`ifndef MULTICORE_JOB_SCHEDULER_MACROS_SVH
`define MULTICORE_JOB_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MJS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MJS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mjs_pkg.sv
package mjs_pkg;

    localparam int NUM_CORES_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 64;

    localparam logic [2:0] SCH_FCFS = 3'd0;
    localparam logic [2:0] SCH_SJF  = 3'd1;
    localparam logic [2:0] SCH_PSJF = 3'd2;
    localparam logic [2:0] SCH_PRI  = 3'd3;
    localparam logic [2:0] SCH_PPRI = 3'd4;
    localparam logic [2:0] SCH_RR   = 3'd5;

    localparam logic [1:0] FN_NEW     = 2'd0;
    localparam logic [1:0] FN_FINISH  = 2'd1;
    localparam logic [1:0] FN_QUANTUM = 2'd2;

    localparam logic [0:0] CFG_SCHEME = 1'b0;
    localparam logic [0:0] CFG_CORES  = 1'b1;

    localparam logic [32:0] NOT_STARTED = {1'b1, 32'd0};

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] urg;
        logic [23:0] rem;
        logic [31:0] arr;
        logic [23:0] total;
        logic [32:0] resp;
    } t_job;

    typedef logic [1:0] t_qop;
    localparam t_qop QOP_INSERT  = 2'd0;
    localparam t_qop QOP_POP     = 2'd1;
    localparam t_qop QOP_REQUEUE = 2'd2;

    typedef struct packed {
        logic go;
        t_qop op;
    } t_q_cmd;

    typedef struct packed {
        logic done;
        logic at_head;
    } t_q_stat;

    // True when job a must stand strictly ahead of job b in the wait queue.
    function automatic logic goes_before(input logic [2:0] sch, input t_job a,
                                         input t_job b);
        logic res;
        res = 1'b0;
        if (sch == SCH_SJF || sch == SCH_PSJF) begin
            res = (a.rem < b.rem);
        end else if (sch == SCH_PRI || sch == SCH_PPRI) begin
            res = (a.urg < b.urg) || ((a.urg == b.urg) && (a.arr < b.arr));
        end
        return res;
    endfunction

endpackage

FILE: rtl/multicore_job_scheduler.sv
// When an idle core k takes a new job, the result strobe follows a scan of cores 0 through k.
// The longest events are a quantum expiry rotating a full queue and the preemptive core
// scans plus a sorted insert into the queue memory. One event at a time: busy is high from
// acceptance through the result strobe. Synchronous active-low reset idles every core and
// empties the queue; no clearing pass. The receiver cannot stall; each result is shown for
// one cycle on o_valid.
module multicore_job_scheduler import mjs_pkg::*; #(
    parameter int NUM_CORES   = NUM_CORES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [3:0]         i_cfg_data,
    input  logic [1:0]         i_func,
    input  logic [15:0]        i_job_id,
    input  logic [31:0]        i_now,
    input  logic [23:0]        i_run_length,
    input  logic [15:0]        i_job_priority,
    input  logic [2:0]         i_core_index,
    output logic               o_valid,
    output logic signed [3:0]  o_assigned_core,
    output logic signed [16:0] o_started_job,
    output logic [31:0]        o_done_wait,
    output logic [31:0]        o_done_turnaround,
    output logic [31:0]        o_done_response,
    output logic               o_queue_overflow
);

    localparam int SW  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int CNW = $clog2(NUM_CORES + 1);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FREE   = 4'd1;
    localparam logic [3:0] S_PSJF   = 4'd2;
    localparam logic [3:0] S_PPRI   = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_EVICT  = 4'd5;
    localparam logic [3:0] S_FIN    = 4'd6;
    localparam logic [3:0] S_QTM    = 4'd7;
    localparam logic [3:0] S_QWAIT  = 4'd8;
    localparam logic [3:0] S_RESULT = 4'd9;

    // Bring a job onto a core: the first dispatch fixes its response time.
    function automatic t_job start_on(input t_job j, input logic [31:0] now);
        t_job res;
        res = j;
        if (j.resp[32]) begin
            res.resp = {1'b0, now - j.arr};
        end
        return res;
    endfunction

    logic [2:0]     r_scheme;
    logic [3:0]     r_cores_cfg;
    logic [CNW-1:0] w_cores;

    logic           r_busy [NUM_CORES];
    t_job           r_slot [NUM_CORES];
    logic [31:0]    r_slot_chk [NUM_CORES];

    logic [3:0]     r_state, n_state;
    logic [1:0]     r_func, n_func;
    logic [15:0]    r_id, n_id;
    logic [31:0]    r_now, n_now;
    logic [23:0]    r_len, n_len;
    logic [15:0]    r_urg, n_urg;
    logic [SW-1:0]  r_sidx, n_sidx;
    logic [23:0]    r_best, n_best;
    logic [15:0]    r_low, n_low;
    logic [31:0]    r_low_arr, n_low_arr;
    logic [SW-1:0]  r_cand, n_cand;
    logic           r_victim, n_victim;
    logic           r_start_head, n_start_head;

    logic [3:0]     r_assigned, n_assigned;
    logic [16:0]    r_started, n_started;
    logic [31:0]    r_wait, n_wait;
    logic [31:0]    r_tat, n_tat;
    logic [31:0]    r_resp, n_resp;
    logic           r_ovf, n_ovf;

    logic           w_swe;
    t_job           w_sdata;
    logic           w_bset;
    logic           w_bclr;
    t_job           w_cur;
    logic [31:0]    w_cur_chk;
    t_job           w_newj;
    logic           w_last;

    t_q_cmd         w_qcmd;
    t_job           w_qjob;
    t_q_stat        w_qstat;
    logic [QCW-1:0] w_qcount;
    t_job           w_qhead;

    always_comb begin
        if (r_cores_cfg == 4'd0) begin
            w_cores = CNW'(1);
        end else if (32'(r_cores_cfg) > NUM_CORES) begin
            w_cores = CNW'(NUM_CORES);
        end else begin
            w_cores = CNW'(r_cores_cfg);
        end
    end

    assign w_cur     = r_slot[r_sidx];
    assign w_cur_chk = r_slot_chk[r_sidx];
    assign w_last    = (CNW'(r_sidx) == (w_cores - CNW'(1)));

    always_comb begin
        w_newj.id    = r_id;
        w_newj.urg   = r_urg;
        w_newj.rem   = r_len;
        w_newj.arr   = r_now;
        w_newj.total = r_len;
        w_newj.resp  = NOT_STARTED;
    end

    always_comb begin
        logic [31:0] el;
        logic [23:0] rr;
        logic [31:0] tat;
        logic        take;
        t_job        v;
        n_state      = r_state;
        n_func       = r_func;
        n_id         = r_id;
        n_now        = r_now;
        n_len        = r_len;
        n_urg        = r_urg;
        n_sidx       = r_sidx;
        n_best       = r_best;
        n_low        = r_low;
        n_low_arr    = r_low_arr;
        n_cand       = r_cand;
        n_victim     = r_victim;
        n_start_head = r_start_head;
        n_assigned   = r_assigned;
        n_started    = r_started;
        n_wait       = r_wait;
        n_tat        = r_tat;
        n_resp       = r_resp;
        n_ovf        = r_ovf;
        w_swe        = 1'b0;
        w_sdata      = start_on(w_newj, r_now);
        w_bset       = 1'b0;
        w_bclr       = 1'b0;
        w_qcmd.go    = 1'b0;
        w_qcmd.op    = QOP_INSERT;
        w_qjob       = w_newj;
        el           = r_now - w_cur_chk;
        rr           = (el >= {8'd0, w_cur.rem}) ? 24'd0 : (w_cur.rem - el[23:0]);
        tat          = r_now - w_cur.arr;
        take         = 1'b0;
        v            = w_cur;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_func       = i_func;
                    n_id         = i_job_id;
                    n_now        = i_now;
                    n_len        = i_run_length;
                    n_urg        = i_job_priority;
                    n_sidx       = '0;
                    n_victim     = 1'b0;
                    n_start_head = 1'b0;
                    n_assigned   = 4'hF;
                    n_started    = 17'h1FFFF;
                    n_wait       = '0;
                    n_tat        = '0;
                    n_resp       = '0;
                    n_ovf        = 1'b0;
                    if (i_func == FN_NEW) begin
                        n_state = S_FREE;
                    end else if (32'(i_core_index) < 32'(w_cores)) begin
                        n_sidx = SW'(i_core_index);
                        if (i_func == FN_FINISH) begin
                            n_state = S_FIN;
                        end else if (i_func == FN_QUANTUM) begin
                            n_state = S_QTM;
                        end else begin
                            n_state = S_RESULT;
                        end
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_FREE: begin
                if (!r_busy[r_sidx]) begin
                    w_swe      = 1'b1;
                    w_bset     = 1'b1;
                    n_assigned = 4'(r_sidx);
                    n_started  = {1'b0, r_id};
                    n_state    = S_RESULT;
                end else if (w_last) begin
                    n_sidx = '0;
                    if (r_scheme == SCH_PSJF) begin
                        n_state = S_PSJF;
                    end else if (r_scheme == SCH_PPRI) begin
                        n_state = S_PPRI;
                    end else begin
                        n_state = S_DECIDE;
                    end
                end else begin
                    n_sidx = r_sidx + SW'(1);
                end
            end
            S_PSJF: begin
                // Age each running job and track the one with the most work left.
                w_swe       = 1'b1;
                w_sdata     = w_cur;
                w_sdata.rem = rr;
                take        = (r_sidx == '0) || (rr > r_best);
                if (take) begin
                    n_best = rr;
                    n_cand = r_sidx;
                end
                if (w_last) begin
                    n_victim = (take ? rr : r_best) > r_len;
                    n_state  = S_DECIDE;
                end else begin
                    n_sidx = r_sidx + SW'(1);
                end
            end
            S_PPRI: begin
                // Least urgent running job; among equals the latest arrival.
                if ((r_sidx == '0) || (w_cur.urg > r_low)) begin
                    take = 1'b1;
                end else if ((w_cur.urg == r_low) && (w_cur.arr > r_low_arr)) begin
                    take = 1'b1;
                end
                if (take) begin
                    n_low     = w_cur.urg;
                    n_low_arr = w_cur.arr;
                    n_cand    = r_sidx;
                end
                if (w_last) begin
                    n_victim = (take ? w_cur.urg : r_low) > r_urg;
                    n_state  = S_DECIDE;
                end else begin
                    n_sidx = r_sidx + SW'(1);
                end
            end
            S_DECIDE: begin
                if (32'(w_qcount) >= QUEUE_DEPTH) begin
                    n_ovf   = 1'b1;
                    n_state = S_RESULT;
                end else if (r_victim) begin
                    n_sidx  = r_cand;
                    n_state = S_EVICT;
                end else begin
                    w_qcmd.go = 1'b1;
                    w_qcmd.op = QOP_INSERT;
                    n_state   = S_QWAIT;
                end
            end
            S_EVICT: begin
                // A job preempted at the instant it started counts as never started.
                if (!v.resp[32] && (v.resp[31:0] == tat)) begin
                    v.resp = NOT_STARTED;
                end
                w_qcmd.go  = 1'b1;
                w_qcmd.op  = QOP_INSERT;
                w_qjob     = v;
                w_swe      = 1'b1;
                n_assigned = 4'(r_sidx);
                n_started  = {1'b0, r_id};
                n_state    = S_QWAIT;
            end
            S_FIN: begin
                if (r_busy[r_sidx]) begin
                    n_tat  = tat;
                    n_wait = tat - {8'd0, w_cur.total};
                    n_resp = w_cur.resp[32] ? 32'd0 : w_cur.resp[31:0];
                    w_bclr = 1'b1;
                end
                if (w_qcount != '0) begin
                    w_qcmd.go    = 1'b1;
                    w_qcmd.op    = QOP_POP;
                    n_start_head = 1'b1;
                    n_state      = S_QWAIT;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_QTM: begin
                if (r_busy[r_sidx]) begin
                    w_qcmd.go    = 1'b1;
                    w_qcmd.op    = QOP_REQUEUE;
                    w_qjob       = w_cur;
                    n_start_head = 1'b1;
                    n_state      = S_QWAIT;
                end else if (w_qcount != '0) begin
                    w_qcmd.go    = 1'b1;
                    w_qcmd.op    = QOP_POP;
                    n_start_head = 1'b1;
                    n_state      = S_QWAIT;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_QWAIT: begin
                if (w_qstat.done) begin
                    if (r_start_head) begin
                        if (w_qstat.at_head) begin
                            n_started = {1'b0, w_cur.id};
                        end else begin
                            w_swe     = 1'b1;
                            w_sdata   = start_on(w_qhead, r_now);
                            w_bset    = 1'b1;
                            n_started = {1'b0, w_qhead.id};
                        end
                    end
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme    <= SCH_FCFS;
            r_cores_cfg <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCHEME: r_scheme    <= i_cfg_data[2:0];
                CFG_CORES:  r_cores_cfg <= i_cfg_data;
                default:    r_scheme    <= r_scheme;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CORES; k++) begin
                r_busy[k] <= 1'b0;
            end
        end else if (w_bset) begin
            r_busy[r_sidx] <= 1'b1;
        end else if (w_bclr) begin
            r_busy[r_sidx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_swe) begin
            r_slot[r_sidx]     <= w_sdata;
            r_slot_chk[r_sidx] <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_id         <= n_id;
        r_now        <= n_now;
        r_len        <= n_len;
        r_urg        <= n_urg;
        r_sidx       <= n_sidx;
        r_best       <= n_best;
        r_low        <= n_low;
        r_low_arr    <= n_low_arr;
        r_cand       <= n_cand;
        r_victim     <= n_victim;
        r_start_head <= n_start_head;
        r_assigned   <= n_assigned;
        r_started    <= n_started;
        r_wait       <= n_wait;
        r_tat        <= n_tat;
        r_resp       <= n_resp;
        r_ovf        <= n_ovf;
    end

    mjs_wait_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_qcmd),
        .i_job   (w_qjob),
        .i_scheme(r_scheme),
        .o_stat  (w_qstat),
        .o_count (w_qcount),
        .o_head  (w_qhead)
    );

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = (r_state == S_RESULT);
    assign o_assigned_core   = signed'(r_assigned);
    assign o_started_job     = signed'(r_started);
    assign o_done_wait       = r_wait;
    assign o_done_turnaround = r_tat;
    assign o_done_response   = r_resp;
    assign o_queue_overflow  = r_ovf;

endmodule

FILE: rtl/mjs_wait_queue.sv
module mjs_wait_queue import mjs_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_q_cmd                             i_cmd,
    input  t_job                               i_job,
    input  logic [2:0]                         i_scheme,
    output t_q_stat                            o_stat,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_count,
    output t_job                               o_head
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] Q_IDLE     = 4'd0;
    localparam logic [3:0] Q_SCAN_RD  = 4'd1;
    localparam logic [3:0] Q_SCAN_CMP = 4'd2;
    localparam logic [3:0] Q_DN_RD    = 4'd3;
    localparam logic [3:0] Q_DN_WR    = 4'd4;
    localparam logic [3:0] Q_PUT      = 4'd5;
    localparam logic [3:0] Q_HEAD_RD  = 4'd6;
    localparam logic [3:0] Q_HEAD_CAP = 4'd7;
    localparam logic [3:0] Q_UP_RD    = 4'd8;
    localparam logic [3:0] Q_UP_WR    = 4'd9;
    localparam logic [3:0] Q_DONE     = 4'd10;

    t_job mem [QUEUE_DEPTH];
    t_job r_rdata;

    logic [3:0]    r_state, n_state;
    t_qop          r_op, n_op;
    t_job          r_job, n_job;
    logic [2:0]    r_scheme, n_scheme;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_lim, n_lim;
    logic [CW-1:0] r_count, n_count;
    t_job          r_head, n_head;
    logic          r_at_head, n_at_head;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    t_job          w_wdata;

    always_comb begin
        logic [CW-1:0] p;
        logic          found;
        n_state   = r_state;
        n_op      = r_op;
        n_job     = r_job;
        n_scheme  = r_scheme;
        n_i       = r_i;
        n_pos     = r_pos;
        n_lim     = r_lim;
        n_count   = r_count;
        n_head    = r_head;
        n_at_head = r_at_head;
        w_we      = 1'b0;
        w_waddr   = r_i[AW-1:0];
        w_raddr   = r_i[AW-1:0];
        w_wdata   = r_rdata;
        p         = r_i;
        found     = 1'b0;
        unique case (r_state)
            Q_IDLE: begin
                if (i_cmd.go) begin
                    n_op      = i_cmd.op;
                    n_job     = i_job;
                    n_scheme  = i_scheme;
                    n_at_head = 1'b0;
                    n_i       = '0;
                    if (i_cmd.op == QOP_POP) begin
                        n_lim   = r_count;
                        n_state = Q_HEAD_RD;
                    end else begin
                        n_state = Q_SCAN_RD;
                    end
                end
            end
            Q_SCAN_RD: begin
                if (r_i == r_count) begin
                    found = 1'b1;
                end else begin
                    n_state = Q_SCAN_CMP;
                end
            end
            Q_SCAN_CMP: begin
                if (goes_before(r_scheme, r_job, r_rdata)) begin
                    found = 1'b1;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = Q_SCAN_RD;
                end
            end
            Q_DN_RD: begin
                w_raddr = AW'(r_i - CW'(1));
                if (r_i == r_pos) begin
                    n_state = Q_PUT;
                end else begin
                    n_state = Q_DN_WR;
                end
            end
            Q_DN_WR: begin
                w_we    = 1'b1;
                w_waddr = r_i[AW-1:0];
                n_i     = r_i - CW'(1);
                n_state = Q_DN_RD;
            end
            Q_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_pos[AW-1:0];
                w_wdata = r_job;
                if (r_op == QOP_INSERT) begin
                    n_count = r_count + CW'(1);
                end
                n_state = Q_DONE;
            end
            Q_HEAD_RD: begin
                w_raddr = '0;
                n_state = Q_HEAD_CAP;
            end
            Q_HEAD_CAP: begin
                n_head  = r_rdata;
                n_i     = CW'(1);
                n_state = Q_UP_RD;
            end
            Q_UP_RD: begin
                if (r_i >= r_lim) begin
                    if (r_op == QOP_POP) begin
                        n_count = r_count - CW'(1);
                        n_state = Q_DONE;
                    end else begin
                        n_pos   = r_lim - CW'(1);
                        n_state = Q_PUT;
                    end
                end else begin
                    n_state = Q_UP_WR;
                end
            end
            Q_UP_WR: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_i - CW'(1));
                n_i     = r_i + CW'(1);
                n_state = Q_UP_RD;
            end
            Q_DONE: begin
                n_state = Q_IDLE;
            end
            default: begin
                n_state = Q_IDLE;
            end
        endcase

        // The insertion point is known: open a gap, leave a requeued job at the head, or rotate the head out.
        if (found) begin
            p     = r_i;
            n_pos = p;
            if (r_op == QOP_INSERT) begin
                n_i     = r_count;
                n_state = Q_DN_RD;
            end else if (p == '0) begin
                n_at_head = 1'b1;
                n_state   = Q_DONE;
            end else begin
                n_lim   = p;
                n_state = Q_HEAD_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_job     <= n_job;
        r_scheme  <= n_scheme;
        r_i       <= n_i;
        r_pos     <= n_pos;
        r_lim     <= n_lim;
        r_head    <= n_head;
        r_at_head <= n_at_head;
    end

    assign o_stat.done    = (r_state == Q_DONE);
    assign o_stat.at_head = r_at_head;
    assign o_count        = r_count;
    assign o_head         = r_head;

endmodule

FILE: rtl/mjs_checker.sv
`include "multicore_job_scheduler_macros.svh"

module mjs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [3:0]  o_assigned_core,
    input logic signed [16:0] o_started_job,
    input logic               o_queue_overflow
);

    `MJS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted transaction did not raise busy")
    `MJS_ASSERT_SAME(a_result_busy, i_clk, i_rst_n, o_valid, busy, "result shown while idle")
    `MJS_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid, "result strobe longer than one cycle")
    `MJS_ASSERT_SAME(a_assign_starts, i_clk, i_rst_n, o_valid && (o_assigned_core != 4'sb1111), o_started_job != 17'h1FFFF, "core assigned without a started job")
    `MJS_ASSERT_SAME(a_drop_nothing, i_clk, i_rst_n, o_valid && o_queue_overflow, (o_assigned_core == 4'sb1111) && (o_started_job == 17'h1FFFF), "dropped job was dispatched")

endmodule

bind multicore_job_scheduler mjs_checker u_mjs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_assigned_core (o_assigned_core),
    .o_started_job   (o_started_job),
    .o_queue_overflow(o_queue_overflow)
);
